[design/soc_pkg.sv]
// ----------------------------------------------------------------------------
// soc_pkg
// shared types and constants of the substring occurrence counter
// ----------------------------------------------------------------------------
package soc_pkg;

  localparam int unsigned MaxNeedleDef  = 8;
  localparam int unsigned CountWidthDef = 32;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned NeedleW    = 64;
  localparam int unsigned LenCfgW    = 4;
  localparam int unsigned SinceW     = 4;
  localparam int unsigned ResultW    = 32;
  localparam int unsigned CfgIndexW  = 1;

  // register indexes of the configuration port
  localparam logic [CfgIndexW-1:0] RegNeedleBytes  = 1'b0;
  localparam logic [CfgIndexW-1:0] RegNeedleLength = 1'b1;

  // per-byte control handed along the cell row and to the counter
  typedef struct packed {
    logic take;   // input request accepted this cycle
    logic last;   // final byte of the haystack, clear afterwards
  } soc_step_t;

endpackage

[design/substring_occurrence_counter.sv]
// ----------------------------------------------------------------------------
// substring_occurrence_counter
// streaming count of non-overlapping needle occurrences in a haystack
// ----------------------------------------------------------------------------
// output: the count is registered and shows in the cycle after the request carrying tlast
// throughput: one byte per cycle, set by the lane compare and
//   counter update; a new byte is taken while a result waits in the output
//   register, and only a held result with tready low stalls the input
// reset: needle bytes zero, needle length one, window, spacing and count clear
// ----------------------------------------------------------------------------
module substring_occurrence_counter
  import soc_pkg::*;
#(
  parameter int unsigned MAX_NEEDLE  = MaxNeedleDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [NeedleW-1:0]   cfg_data_i,
  // haystack byte stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ByteW-1:0]     s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,   // end_of_data
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [ResultW-1:0]   m_axis_tdata    // [31:0] match_count
);

  localparam int unsigned LenW = $clog2(MAX_NEEDLE + 1);

  // configuration registers
  logic [NeedleW-1:0] needle_q, needle_d;
  logic [LenW-1:0]    len_q, len_d;       // effective length, 1..MAX_NEEDLE
  logic [LenCfgW-1:0] len_raw;

  // lane bytes: lane 0 is the byte in flight, lane k the byte k accepted requests earlier
  logic [ByteW-1:0]      lane_byte [MAX_NEEDLE+1];
  logic [MAX_NEEDLE-1:0] lane_match;
  soc_step_t             step;

  assign cfg_ready_o = 1'b1;
  assign len_raw     = cfg_data_i[LenCfgW-1:0];

  // length zero acts as one, anything above the row as the full row
  always_comb begin
    needle_d = needle_q;
    len_d    = len_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegNeedleBytes: begin
          needle_d = cfg_data_i;
        end
        RegNeedleLength: begin
          if (len_raw == '0) begin
            len_d = LenW'(1);
          end else if ({1'b0, len_raw} > (LenCfgW+1)'(MAX_NEEDLE)) begin
            len_d = LenW'(MAX_NEEDLE);
          end else begin
            len_d = LenW'(len_raw);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
      len_q    <= LenW'(1);
    end else begin
      needle_q <= needle_d;
      len_q    <= len_d;
    end
  end

  // input stalls only while a finished count is still held
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step.take     = s_axis_tvalid && s_axis_tready;
  assign step.last     = s_axis_tlast;

  assign lane_byte[0] = s_axis_tdata;

  // row of lane cells, each shifting its byte one lane further per request
  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_lane
    soc_cell #(
      .MAX_NEEDLE (MAX_NEEDLE),
      .LANE       (k),
      .LEN_W      (LenW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step),
      .byte_i   (lane_byte[k]),
      .needle_i (needle_q),
      .len_i    (len_q),
      .match_o  (lane_match[k]),
      .byte_o   (lane_byte[k+1])
    );
  end

  // a hit needs every active lane to agree and enough bytes since the last hit
  soc_count #(
    .MAX_NEEDLE  (MAX_NEEDLE),
    .COUNT_WIDTH (COUNT_WIDTH),
    .LEN_W       (LenW)
  ) u_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .lanes_match_i (&lane_match),
    .len_i         (len_q),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_count_o   (m_axis_tdata)
  );

endmodule

[design/soc_cell.sv]
// ----------------------------------------------------------------------------
// soc_cell
// one window lane: compares its byte with the needle byte for its lane
// and hands the byte on to the next lane
// ----------------------------------------------------------------------------
module soc_cell
  import soc_pkg::*;
#(
  parameter int unsigned MAX_NEEDLE = MaxNeedleDef,
  parameter int unsigned LANE       = 0,
  parameter int unsigned LEN_W      = $clog2(MAX_NEEDLE + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  soc_step_t          step_i,
  input  logic [ByteW-1:0]   byte_i,
  input  logic [NeedleW-1:0] needle_i,
  input  logic [LEN_W-1:0]   len_i,
  output logic               match_o,
  output logic [ByteW-1:0]   byte_o
);

  localparam logic [LEN_W-1:0] LaneC = LEN_W'(LANE);

  logic [ByteW-1:0] byte_q, byte_d;
  logic [LEN_W-1:0] idx;
  logic [2:0]       sel;

  // needle byte that meets this lane is number len-1-lane
  always_comb begin
    idx = len_i - LaneC - LEN_W'(1);
    sel = 3'(idx);
    if (len_i <= LaneC) begin
      match_o = 1'b1;
    end else begin
      match_o = (byte_i == needle_i[{sel, 3'b000} +: ByteW]);
    end
  end

  always_comb begin
    byte_d = byte_q;
    if (step_i.take) begin
      byte_d = step_i.last ? '0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

[design/soc_count.sv]
// ----------------------------------------------------------------------------
// soc_count
// spacing tracker, saturating match counter and result register
// ----------------------------------------------------------------------------
module soc_count
  import soc_pkg::*;
#(
  parameter int unsigned MAX_NEEDLE  = MaxNeedleDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef,
  parameter int unsigned LEN_W       = $clog2(MAX_NEEDLE + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  soc_step_t          step_i,
  input  logic               lanes_match_i,
  input  logic [LEN_W-1:0]   len_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [ResultW-1:0] out_count_o
);

  logic [SinceW-1:0]      since_q, since_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d, count_new;
  logic                   out_valid_q, out_valid_d;
  logic [ResultW-1:0]     out_count_q, out_count_d;
  logic [SinceW:0]        avail;
  logic                   hit;

  assign avail = {1'b0, since_q} + (SinceW+1)'(1);
  assign hit   = lanes_match_i && (avail >= (SinceW+1)'(len_i));

  always_comb begin
    count_new = count_q;
    if (hit && (count_q != '1)) begin
      count_new = count_q + COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    since_d     = since_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_count_d = out_count_q;
    if (step_i.take) begin
      if (hit) begin
        since_d = '0;
      end else if (since_q != '1) begin
        since_d = avail[SinceW-1:0];
      end
      count_d = count_new;
      if (step_i.last) begin
        since_d     = '0;
        count_d     = '0;
        out_valid_d = 1'b1;
        // result keeps the low bits of the count, zero-filled when narrower
        out_count_d = ResultW'(count_new);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      since_q     <= since_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;

endmodule

[verif/tb_substring_occurrence_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_substring_occurrence_counter
// self-checking bench for the non-overlapping needle occurrence counter
// ----------------------------------------------------------------------------
// haystack bytes go in through a bursty sender while the result side stalls
// on a changing pattern. a byte-level predictor follows every accepted
// byte and queues the count due on each final byte; each returned count is
// compared against the oldest queued one. directed haystacks cover the
// byte extremes, overlapping repeats, a full-width needle ending on the
// final byte and needle length clamping; the random part plants whole and
// broken needle copies in haystacks of mixed length, and reprograms the
// needle between phases, sometimes with a haystack still open
// ----------------------------------------------------------------------------
module tb_substring_occurrence_counter;
  import soc_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 1150;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned SettleGap   = 4;
  localparam int unsigned SpacingMax  = 15;

  // ready patterns of the result side
  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyRandom,
    ReadySparse,
    ReadyBursty
  } ready_mode_e;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i   = RegNeedleBytes;
  logic [NeedleW-1:0]   cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata  = '0;   // [7:0] data_byte
  logic                 s_axis_tlast  = 1'b0; // end_of_data
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [ResultW-1:0]   m_axis_tdata;         // [31:0] match_count

  substring_occurrence_counter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predictor copy of the needle registers
  logic [NeedleW-1:0] needle_q     = '0;
  logic [LenCfgW-1:0] needle_len_q = 4'd1;

  // predictor copy of the search state
  logic [55:0]        pred_window  = '0;
  logic [SinceW-1:0]  pred_since   = '0;
  logic [ResultW-1:0] pred_count   = '0;

  // counts owed by the block, oldest first
  logic [ResultW-1:0] expected_counts[$];

  int unsigned cycle_cnt       = 0;
  int unsigned items_sent      = 0;
  int unsigned hays_sent       = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned mismatches      = 0;

  // sender burst shaping
  int unsigned burst_left = 0;
  logic        gapless    = 1'b0;

  // result side stall pattern
  ready_mode_e ready_mode  = ReadyAlways;
  int unsigned ready_timer = 0;

  logic [ResultW-1:0] owed_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a correct run finishes far below this
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d counts still owed",
               cycle_cnt, expected_counts.size());
      $display("status: fail");
      $finish;
    end
  end

  // result side: switches between always ready, coin toss, sparse and
  // long stalls so that back-pressure lands on every part of a haystack
  always @(posedge clk_i) begin
    if (ready_timer == 0) begin
      ready_mode  <= ready_mode_e'($urandom_range(0, 3));
      ready_timer <= $urandom_range(20, 120);
    end else begin
      ready_timer <= ready_timer - 1;
    end
    case (ready_mode)
      ReadyAlways: m_axis_tready <= 1'b1;
      ReadyRandom: m_axis_tready <= 1'($urandom_range(0, 1));
      ReadySparse: m_axis_tready <= ((cycle_cnt % 5) == 0);
      default:     m_axis_tready <= ((cycle_cnt % 40) >= 30);
    endcase
  end

  task automatic report_mismatch(input string what, input logic [ResultW-1:0] want,
                                 input logic [ResultW-1:0] got);
    mismatches++;
    if (mismatches <= ReportMax)
      $display("mismatch at cycle %0d: %s, match_count expected %0d got %0d",
               cycle_cnt, what, want, got);
  endtask

  // result check: every accepted count against the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_counts.size() == 0) begin
        report_mismatch("unexpected result", '0, m_axis_tdata);
      end else begin
        owed_count = expected_counts.pop_front();
        results_checked++;
        if (m_axis_tdata !== owed_count)
          report_mismatch("wrong count", owed_count, m_axis_tdata);
      end
    end
  end

  // length zero counts as one, anything above eight as eight
  function automatic int unsigned effective_len();
    int unsigned len;
    len = 32'(needle_len_q);
    if (len == 0) len = 1;
    if (len > 8) len = 8;
    return len;
  endfunction

  // advance the search state by one accepted byte; on the final byte the
  // count is owed and the state starts over
  function automatic void occurrence_predict(input logic [ByteW-1:0] cur,
                                             input logic last_b);
    logic [63:0] hist;
    logic [4:0]  avail;
    int unsigned len;
    int unsigned j;
    logic        hit;
    len   = effective_len();
    hist  = {pred_window, cur};
    avail = {1'b0, pred_since} + 5'd1;
    // too close to the previous match: no new one may start yet
    hit   = (avail >= len);
    // the oldest byte of the candidate sits in the highest lane used
    for (j = 0; j < len; j++)
      if (hist[(len - 1 - j) * 8 +: 8] != needle_q[j * 8 +: 8]) hit = 1'b0;
    if (hit) begin
      if (pred_count != '1) pred_count = pred_count + 1;
      pred_since = '0;
    end else begin
      pred_since = (avail > SpacingMax) ? SinceW'(SpacingMax) : avail[SinceW-1:0];
    end
    pred_window = hist[55:0];
    if (last_b) begin
      expected_counts.push_back(pred_count);
      hays_sent++;
      pred_window = '0;
      pred_since  = '0;
      pred_count  = '0;
    end
  endfunction

  // one haystack byte request, with the burst and gap shaping of the sender
  task automatic send_byte(input logic [ByteW-1:0] data_b, input logic last_b);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!gapless && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data_b;
    s_axis_tlast  <= last_b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    occurrence_predict(data_b, last_b);
  endtask

  task automatic stop_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold the sender until every owed count is back, then let the block
  // settle: a byte without a result may still be in flight
  task automatic wait_idle();
    stop_stream();
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [NeedleW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == RegNeedleBytes) needle_q = val;
    else needle_len_q = val[LenCfgW-1:0];
    cfg_writes++;
  endtask

  task automatic configure(input logic [NeedleW-1:0] needle, input logic [LenCfgW-1:0] len);
    write_reg(RegNeedleBytes, needle);
    write_reg(RegNeedleLength, NeedleW'(len));
  endtask

  // reset needle is a single zero byte: each zero byte is a match
  task automatic test_default_needle();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // "aa" in "aaaaa" counts twice, not four times; upper lanes are ignored
  task automatic test_overlapping_repeat();
    wait_idle();
    configure(64'hFFFF_FFFF_FFFF_6161, 4'd2);
    repeat (4) send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b1);
  endtask

  // eight-byte needle completed by the final byte of the haystack
  task automatic test_full_needle_at_end();
    int unsigned j;
    wait_idle();
    configure(64'h0123_4567_89AB_CDEF, 4'd8);
    send_byte(8'h00, 1'b0);
    for (j = 0; j < 8; j++) send_byte(needle_q[j * 8 +: 8], (j == 7));
  endtask

  // length zero behaves as one, length fifteen as eight
  task automatic test_length_clamping();
    wait_idle();
    configure(64'h0000_0000_0000_005A, 4'd0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b1);
    wait_idle();
    configure('1, 4'd15);
    repeat (7) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_random_stream();
    int unsigned target;
    int unsigned phase_no;
    int unsigned hay_left;
    int unsigned plant_pos;
    int unsigned len_eff;
    int unsigned k;
    logic        planting;
    logic [7:0]  pick_a;
    logic [7:0]  pick_b;
    logic [NeedleW-1:0] needle;
    logic [LenCfgW-1:0] len;
    logic [ByteW-1:0]   data_b;
    target   = items_sent + RandomItems;
    phase_no = 0;
    hay_left = 0;
    while (items_sent < target) begin
      // reprogram while idle; an open haystack keeps its state across this
      wait_idle();
      pick_a = 8'($urandom_range(0, 255));
      pick_b = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
        0: needle = '0;
        1: needle = '1;
        2: needle = {8{pick_a}};
        3: for (k = 0; k < 8; k++) needle[k * 8 +: 8] = $urandom_range(0, 1) ? pick_a : pick_b;
        default: needle = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 9))
        0: len = 4'd1;
        1: len = 4'd8;
        2: len = 4'd0;
        3: len = 4'($urandom_range(9, 15));
        default: len = 4'($urandom_range(1, 8));
      endcase
      // the first two phases pin the length extremes
      if (phase_no == 0) len = 4'd8;
      if (phase_no == 1) len = 4'd1;
      if ($urandom_range(0, 1)) begin
        configure(needle, len);
      end else begin
        write_reg(RegNeedleLength, NeedleW'(len));
        write_reg(RegNeedleBytes, needle);
      end
      len_eff  = effective_len();
      gapless  = ($urandom_range(0, 4) == 0);
      planting = 1'b0;
      plant_pos = 0;
      repeat ($urandom_range(60, 200)) begin
        if (items_sent >= target) break;
        if (hay_left == 0)
          hay_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                                 : $urandom_range(1, 24);
        if (planting) begin
          data_b = needle_q[plant_pos * 8 +: 8];
          plant_pos++;
          // a copy is sometimes broken off early
          if (plant_pos >= len_eff || $urandom_range(0, 19) == 0) planting = 1'b0;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              data_b    = needle_q[7:0];
              plant_pos = 1;
              planting  = (len_eff > 1);
            end
            5, 6, 7: data_b = needle_q[$urandom_range(0, len_eff - 1) * 8 +: 8];
            default: data_b = 8'($urandom_range(0, 255));
          endcase
        end
        hay_left--;
        send_byte(data_b, (hay_left == 0));
      end
      phase_no++;
    end
    // close the haystack still open
    while (hay_left != 0) begin
      hay_left--;
      send_byte(8'($urandom_range(0, 255)), (hay_left == 0));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_needle();
    test_overlapping_repeat();
    test_full_needle_at_end();
    test_length_clamping();
    test_random_stream();

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d bytes in %0d haystacks, checked %0d counts",
             items_sent, hays_sent, results_checked);
    $display("needle reprogrammed with %0d register writes, %0d mismatches",
             cfg_writes, mismatches);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
